@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge, reset masks it
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/tgi_pkg.sv @@
// Package for the turtle graphics interpreter: types, codes, CORDIC constants.
// No dependencies.
package tgi_pkg;
    typedef enum logic [3:0] {
        ACT_NONE = 4'd0, ACT_DRAW = 4'd1, ACT_MOVE = 4'd2, ACT_LEFT = 4'd3,
        ACT_RIGHT = 4'd4, ACT_PUSH = 4'd5, ACT_POP = 4'd6, ACT_PUSH_LEFT = 4'd7,
        ACT_POP_RIGHT = 4'd8
    } act_code_t;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_START_HEADING = 3'd2;
    localparam logic [2:0] REG_STEP_LENGTH = 3'd3;
    localparam logic [2:0] REG_TURN_ANGLE = 3'd4;
    localparam logic [2:0] REG_ACTIONS_A = 3'd5;
    localparam logic [2:0] REG_ACTIONS_B = 3'd6;
    localparam logic [2:0] REG_SYMBOL_COUNT = 3'd7;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_FULL = 2'd1;
    localparam logic [1:0] FAULT_EMPTY = 2'd2;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_EXEC, ST_POPRD, ST_CORDIC, ST_MUL, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [15:0] heading;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                5'd0: r = 34'sh20000000;  5'd1: r = 34'sh12E4051E;
                5'd2: r = 34'sh09FB385B;  5'd3: r = 34'sh051111D4;
                5'd4: r = 34'sh028B0D43;  5'd5: r = 34'sh0145D7E1;
                5'd6: r = 34'sh00A2F61E;  5'd7: r = 34'sh00517C55;
                5'd8: r = 34'sh0028BE53;  5'd9: r = 34'sh00145F2F;
                5'd10: r = 34'sh000A2F98; 5'd11: r = 34'sh000517CC;
                5'd12: r = 34'sh00028BE6; 5'd13: r = 34'sh000145F3;
                5'd14: r = 34'sh0000A2FA; 5'd15: r = 34'sh0000517D;
                5'd16: r = 34'sh000028BE; 5'd17: r = 34'sh0000145F;
                5'd18: r = 34'sh00000A30; 5'd19: r = 34'sh00000518;
                5'd20: r = 34'sh0000028C; 5'd21: r = 34'sh00000146;
                5'd22: r = 34'sh000000A3; 5'd23: r = 34'sh00000051;
                default: r = 34'sh0;
            endcase
            return r;
        end
    endfunction
endpackage

@@ rtl/core/tgi_cordic.sv @@
// Iterative CORDIC rotator: one micro-rotation per cycle, one shared adder set.
// Depends on tgi_pkg.
module tgi_cordic import tgi_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [SW-1:0] step_reg, step_next;
    logic busy_reg, busy_next, flip_reg, flip_next, done_reg, done_next;
    logic [15:0] h_fold;
    logic fold;
    logic signed [33:0] xs, ys;

    always_comb begin
        fold = (req.heading > 16'h4000) && (req.heading < 16'hC000);
        h_fold = fold ? req.heading + 16'h8000 : req.heading;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (req.start) begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = {{2{h_fold[15]}}, h_fold, 16'h0};
            step_next = '0;
            busy_next = 1'b1;
            flip_next = fold;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_lut(5'(step_reg));
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_lut(5'(step_reg));
            end
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        step_reg <= step_next;
        flip_reg <= flip_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.cos_v = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_v = flip_reg ? -y_reg : y_reg;
endmodule

@@ rtl/core/tgi_stack.sv @@
// Pose stack memory, one write or one read per cycle, registered read data.
// Depends on tgi_pkg.
module tgi_stack import tgi_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [79:0]   wr_data,
    output logic [79:0]   rd_data
);
    logic [79:0] mem [STACK_DEPTH];
    logic [79:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_reg <= mem[addr];
    end

    assign rd_data = rd_reg;
endmodule

@@ rtl/core/turtle_graphics_interpreter_top.sv @@
// Turtle graphics interpreter: symbol items in, one result per matching table entry.
// The scan checks up to MAX_SYMBOLS entries, one per cycle; a forward move adds the
// CORDIC iterations and two multiply steps (cos, then sin), a pop adds the stack read.
// An item with bit 0 set only resets the pose and gives no result.
// One item is held at a time, s_tready low meanwhile.
// Reset (aresetn, synchronous, active low) returns state, pose, stack fill and config
// registers to their defaults; stack contents are left unwritten.
module turtle_graphics_interpreter_top import tgi_pkg::*; #(
    parameter int STACK_DEPTH  = 64,
    parameter int MAX_SYMBOLS  = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [0] reset pose, [8:1] symbol, rest zero
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // has_segment, start_x, start_y, end_x, end_y, fault
    output logic         m_tlast
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // configuration registers
    logic [31:0] start_x_reg, start_y_reg;
    logic [15:0] start_heading_reg, turn_angle_reg;
    logic [30:0] step_length_reg;
    logic [95:0] actions_reg;
    logic [3:0]  symbol_count_reg;

    // pose and control
    state_t state_reg, state_next;
    logic [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [15:0] heading_reg, heading_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [7:0] sym_reg, sym_next;
    logic [3:0] entry_reg, entry_next;
    logic [3:0] code_reg, code_next;
    logic [3:0] nvalid;
    // result holding register
    logic out_seg_reg, out_seg_next;
    logic [31:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [1:0] fault_reg, fault_next;
    // shared multiplier operand and product
    logic signed [33:0] mul_a_reg, mul_a_next, sin_reg, sin_next;
    logic signed [65:0] prod;
    logic mul_phase_reg, mul_phase_next;

    cordic_req_t creq;
    cordic_rsp_t crsp;
    logic st_we;
    logic [AW-1:0] st_addr;
    logic [79:0] st_rd;

    tgi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp)
    );

    tgi_stack #(.STACK_DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .aclk(aclk), .wr_en(st_we), .addr(st_addr),
        .wr_data({pos_x_reg, pos_y_reg, heading_reg}), .rd_data(st_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_heading_reg <= '0;
            step_length_reg <= 31'd65536;
            turn_angle_reg <= 16'd16384;
            actions_reg <= '0;
            symbol_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_X:       start_x_reg <= cfg_wdata[31:0];
                REG_START_Y:       start_y_reg <= cfg_wdata[31:0];
                REG_START_HEADING: start_heading_reg <= cfg_wdata[15:0];
                REG_STEP_LENGTH:   step_length_reg <= cfg_wdata[30:0];
                REG_TURN_ANGLE:    turn_angle_reg <= cfg_wdata[15:0];
                REG_ACTIONS_A:     actions_reg[47:0] <= cfg_wdata;
                REG_ACTIONS_B:     actions_reg[95:48] <= cfg_wdata;
                REG_SYMBOL_COUNT:  symbol_count_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign nvalid = (symbol_count_reg > 4'(MAX_SYMBOLS)) ? 4'(MAX_SYMBOLS)
                                                         : symbol_count_reg;
    // one multiplier, shared: cos product first, then sin product
    assign prod = $signed({1'b0, step_length_reg}) * mul_a_reg;

    // does any later valid entry match the current symbol
    logic more_match;
    always_comb begin
        more_match = 1'b0;
        for (int e = 0; e < 8; e++) begin
            if (4'(e) > entry_reg && 4'(e) < nvalid && actions_reg[12*e +: 8] == sym_reg)
                more_match = 1'b1;
        end
    end

    logic [11:0] cur_ent;
    assign cur_ent = actions_reg[12*entry_reg[2:0] +: 12];

    always_comb begin
        state_next = state_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        heading_next = heading_reg;
        depth_next = depth_reg;
        sym_next = sym_reg;
        entry_next = entry_reg;
        code_next = code_reg;
        out_seg_next = out_seg_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        fault_next = fault_reg;
        mul_a_next = mul_a_reg;
        sin_next = sin_reg;
        mul_phase_next = mul_phase_reg;
        creq.start = 1'b0;
        creq.heading = heading_reg;
        st_we = 1'b0;
        st_addr = depth_reg[AW-1:0];
        s_tready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        pos_x_next = start_x_reg;
                        pos_y_next = start_y_reg;
                        heading_next = start_heading_reg;
                        depth_next = '0;
                    end else begin
                        sym_next = s_tdata[8:1];
                        entry_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (entry_reg >= nvalid) begin
                    state_next = ST_IDLE;
                end else if (cur_ent[7:0] == sym_reg) begin
                    code_next = cur_ent[11:8];
                    state_next = ST_EXEC;
                end else begin
                    entry_next = entry_reg + 1'b1;
                end
            end
            ST_EXEC: begin
                out_seg_next = 1'b0;
                sx_next = '0;
                sy_next = '0;
                fault_next = FAULT_NONE;
                state_next = ST_OUT;
                unique case (code_reg)
                    ACT_DRAW, ACT_MOVE: begin
                        out_seg_next = (code_reg == ACT_DRAW);
                        sx_next = (code_reg == ACT_DRAW) ? pos_x_reg : '0;
                        sy_next = (code_reg == ACT_DRAW) ? pos_y_reg : '0;
                        creq.start = 1'b1;
                        state_next = ST_CORDIC;
                    end
                    ACT_LEFT: heading_next = heading_reg + turn_angle_reg;
                    ACT_RIGHT: heading_next = heading_reg - turn_angle_reg;
                    ACT_PUSH, ACT_PUSH_LEFT: begin
                        if (depth_reg >= DW'(STACK_DEPTH)) begin
                            fault_next = FAULT_FULL;
                        end else begin
                            st_we = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                        if (code_reg == ACT_PUSH_LEFT)
                            heading_next = heading_reg + turn_angle_reg;
                    end
                    ACT_POP, ACT_POP_RIGHT: begin
                        if (depth_reg == '0) begin
                            fault_next = FAULT_EMPTY;
                            if (code_reg == ACT_POP_RIGHT)
                                heading_next = heading_reg - turn_angle_reg;
                        end else begin
                            depth_next = depth_reg - 1'b1;
                            st_addr = AW'(depth_reg - 1'b1);
                            state_next = ST_POPRD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_POPRD: begin
                pos_x_next = st_rd[79:48];
                pos_y_next = st_rd[47:16];
                heading_next = (code_reg == ACT_POP_RIGHT) ? st_rd[15:0] - turn_angle_reg
                                                           : st_rd[15:0];
                state_next = ST_OUT;
            end
            ST_CORDIC: begin
                if (crsp.done) begin
                    mul_a_next = crsp.cos_v;
                    sin_next = crsp.sin_v;
                    mul_phase_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!mul_phase_reg) begin
                    pos_x_next = pos_x_reg + prod[61:30];
                    mul_a_next = sin_reg;
                    mul_phase_next = 1'b1;
                end else begin
                    pos_y_next = pos_y_reg + prod[61:30];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    entry_next = entry_reg + 1'b1;
                    state_next = more_match ? ST_SCAN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
        entry_reg <= entry_next;
        code_reg <= code_next;
        out_seg_reg <= out_seg_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        fault_reg <= fault_next;
        mul_a_reg <= mul_a_next;
        sin_reg <= sin_next;
        mul_phase_reg <= mul_phase_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            heading_reg <= '0;
            depth_reg <= '0;
        end else begin
            state_reg <= state_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            heading_reg <= heading_next;
            depth_reg <= depth_next;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast = !more_match;
    assign m_tdata = {5'd0, fault_reg,
                      out_seg_reg ? pos_y_reg : 32'd0,
                      out_seg_reg ? pos_x_reg : 32'd0,
                      sy_reg, sx_reg, out_seg_reg};
endmodule

@@ rtl/core/tgi_checker.sv @@
// Port-level checker for the turtle graphics interpreter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tgi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `CHK_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input taken while result pending")
    `CHK_IMPL(a_fault_code, aclk, aresetn, m_tvalid, m_tdata[130:129] != 2'd3, "bad fault code")
    `CHK_IMPL(a_seg_nofault, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[130:129] == 2'd0, "segment with fault")
endmodule

bind turtle_graphics_interpreter_top tgi_checker u_tgi_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
